>>> design/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants of the countdown timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int COUNT_W        = 16;
    localparam int MASK_W         = 16;
    localparam int TIME_W         = 32;
    localparam int STEP_W         = 8;
    localparam int INDEX_W        = 8;
    localparam int CMD_W          = 3;

    localparam logic [STEP_W-1:0] STEP_RST = 8'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_INIT  = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_SET   = 3'd4,
        CMD_CLEAR = 3'd5,
        CMD_QUERY = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_APPLY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic cmd_ready;
        logic walk;
        logic apply;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

>>> design/ctb_if.sv
// ----------------------------------------------------------------------------
// ctb_if
// Channels of the countdown timer bank: command, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctb_cmd_if;
    import ctb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [INDEX_W-1:0]   timer_index;
    logic [COUNT_W-1:0]   new_time;

    modport source (output valid, cmd, timer_index, new_time, input ready);
    modport sink   (input valid, cmd, timer_index, new_time, output ready);
endinterface

interface ctb_res_if;
    import ctb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 addr_active;
    logic                 addr_expired;
    logic [MASK_W-1:0]    active_mask;
    logic [MASK_W-1:0]    expired_mask;
    logic [TIME_W-1:0]    time_ms;
    logic                 index_error;

    modport source (output valid, addr_active, addr_expired, active_mask,
                    expired_mask, time_ms, index_error, input ready);
    modport sink   (input valid, addr_active, addr_expired, active_mask,
                    expired_mask, time_ms, index_error, output ready);
endinterface

interface ctb_cfg_if;
    import ctb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STEP_W-1:0]    tick_step_ms;

    modport source (output valid, tick_step_ms, input ready);
    modport sink   (input valid, tick_step_ms, output ready);
endinterface

`default_nettype wire

>>> design/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ram #(
    parameter int  W  = 16,
    parameter int  D  = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/ctb_dec.sv
// ----------------------------------------------------------------------------
// ctb_dec
// Shared count decrementer: masks a never-written count to zero, subtracts
// one and flags expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_dec
    import ctb_pkg::*;
(
    input  wire logic               i_known,
    input  wire logic [COUNT_W-1:0] i_count,
    output logic      [COUNT_W-1:0] o_next,
    output logic                    o_zero
);

    logic [COUNT_W-1:0] cur;

    assign cur    = i_known ? i_count : '0;
    assign o_next = cur - COUNT_W'(1);
    assign o_zero = (o_next == '0);

endmodule

`default_nettype wire

>>> design/countdown_timer_bank_top.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank_top
// Bank of one-shot countdown timers with a running millisecond timestamp.
// ----------------------------------------------------------------------------
// Each command word yields one result word. A tick passes through the walk,
// drain and output states, its result word being loaded in the output state:
// the counters live in one RAM with a single read and a single write port,
// and one shared decrementer walks them one per cycle, reading timer n while
// writing back timer n-1. Every other command passes through the apply and
// output states, its result word likewise being loaded in the output state.
// No new command is taken until the current one has been handed to the result
// register, which holds a finished word while the next command is accepted; a
// word left waiting there holds the bank in its last cycle until it is taken.
// Counters are qualified by per-entry valid bits cleared at reset, so no
// clearing pass is needed after reset. Neither commands nor config words are
// taken during reset. tick_step_ms is written through the config channel; the
// user must do so only while the bank is idle; the block does not enforce it.
`default_nettype none

module countdown_timer_bank_top
    import ctb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ctb_cmd_if.sink    i_cmd,
    ctb_res_if.source  o_res,
    ctb_cfg_if.sink    i_cfg
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MW = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;

    t_state                 r_state;
    t_state                 n_state;
    t_ctrl                  ctrl;

    logic [CMD_W-1:0]       r_cmd;
    logic [INDEX_W-1:0]     r_idx;
    logic [COUNT_W-1:0]     r_load;
    logic [AW-1:0]          r_rd_ptr;
    logic                   r_wb_en;
    logic [AW-1:0]          r_wb_ptr;
    logic                   r_wb_vld;
    logic [NUM_TIMERS-1:0]  r_active;
    logic [NUM_TIMERS-1:0]  r_expired;
    logic [NUM_TIMERS-1:0]  r_valid;
    logic [TIME_W-1:0]      r_time;
    logic [STEP_W-1:0]      r_step;

    logic                   r_out_valid;
    logic                   r_res_active;
    logic                   r_res_expired;
    logic [MASK_W-1:0]      r_res_amask;
    logic [MASK_W-1:0]      r_res_emask;
    logic [TIME_W-1:0]      r_res_time;
    logic                   r_res_err;

    logic                   cmd_acc;
    logic                   in_range;
    logic [AW-1:0]          idx_a;
    logic                   is_tick;
    logic                   wb_hit;
    logic                   ld_hit;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_W-1:0]     ram_wdata;
    logic [COUNT_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]     dec_next;
    logic                   dec_zero;
    logic [MW-1:0]          amask_pad;
    logic [MW-1:0]          emask_pad;

    assign cmd_acc  = i_cmd.valid && ctrl.cmd_ready;
    assign in_range = (32'(r_idx) < NUM_TIMERS);
    assign idx_a    = r_idx[AW-1:0];
    assign is_tick  = (t_cmd'(r_cmd) == CMD_TICK);

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = (t_cmd'(i_cmd.cmd) == CMD_TICK) ? S_WALK : S_APPLY;
                end
            end
            S_WALK: begin
                if (r_rd_ptr == AW'(NUM_TIMERS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_OUT;
            S_APPLY: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            S_IDLE:  ctrl.cmd_ready = i_rst_n;
            S_WALK:  ctrl.walk      = 1'b1;
            S_DRAIN: ctrl           = '0;
            S_APPLY: ctrl.apply     = 1'b1;
            S_OUT:   ctrl.out_load  = !r_out_valid || o_res.ready;
            default: ctrl           = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch command word
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_cmd  <= i_cmd.cmd;
            r_idx  <= i_cmd.timer_index;
            r_load <= i_cmd.new_time;
        end
    end

    // walk pointer and write-back pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wb_en  <= 1'b0;
        end else begin
            r_wb_en <= ctrl.walk;
            if (cmd_acc) begin
                r_rd_ptr <= '0;
            end else if (ctrl.walk) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_ptr <= r_rd_ptr;
        r_wb_vld <= r_valid[r_rd_ptr];
    end

    ctb_dec u_dec (
        .i_known (r_wb_vld),
        .i_count (ram_rdata),
        .o_next  (dec_next),
        .o_zero  (dec_zero)
    );

    assign wb_hit = r_wb_en && r_active[r_wb_ptr];
    assign ld_hit = ctrl.apply && in_range &&
                    (t_cmd'(r_cmd) == CMD_INIT || t_cmd'(r_cmd) == CMD_SET);

    assign ram_we    = wb_hit || ld_hit;
    assign ram_waddr = ld_hit ? idx_a : r_wb_ptr;
    assign ram_wdata = ld_hit ? r_load : dec_next;

    ctb_ram #(
        .W (COUNT_W),
        .D (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // flags, valid bits, timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_expired <= '0;
            r_valid   <= '0;
            r_time    <= '0;
        end else begin
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (cmd_acc && t_cmd'(i_cmd.cmd) == CMD_TICK) begin
                r_time <= r_time + TIME_W'(r_step);
            end
            if (wb_hit && dec_zero) begin
                r_active[r_wb_ptr]  <= 1'b0;
                r_expired[r_wb_ptr] <= 1'b1;
            end
            if (ctrl.apply && in_range) begin
                case (t_cmd'(r_cmd))
                    CMD_INIT: begin
                        r_active[idx_a]  <= 1'b1;
                        r_expired[idx_a] <= 1'b0;
                    end
                    CMD_START: r_active[idx_a]  <= 1'b1;
                    CMD_STOP:  r_active[idx_a]  <= 1'b0;
                    CMD_CLEAR: r_expired[idx_a] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // config register
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RST;
        end else if (i_cfg.valid) begin
            r_step <= i_cfg.tick_step_ms;
        end
    end

    // result register
    assign amask_pad = MW'(r_active);
    assign emask_pad = MW'(r_expired);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_res_active  <= in_range && r_active[idx_a];
            r_res_expired <= in_range && r_expired[idx_a];
            r_res_amask   <= amask_pad[MASK_W-1:0];
            r_res_emask   <= emask_pad[MASK_W-1:0];
            r_res_time    <= r_time;
            r_res_err     <= !in_range && !is_tick;
        end
    end

    assign i_cmd.ready         = ctrl.cmd_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.addr_active   = r_res_active;
    assign o_res.addr_expired  = r_res_expired;
    assign o_res.active_mask   = r_res_amask;
    assign o_res.expired_mask  = r_res_emask;
    assign o_res.time_ms       = r_res_time;
    assign o_res.index_error   = r_res_err;

    a_tick_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && t_cmd'(i_cmd.cmd) == CMD_TICK)
        |=> r_time == $past(r_time) + TIME_W'($past(r_step)))
        else $error("timestamp did not advance by step on tick");

    a_wb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_en |-> (32'(r_wb_ptr) < NUM_TIMERS))
        else $error("write-back beyond last timer");

    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wb_hit && ctrl.apply))
        else $error("walk write-back overlaps command write");

    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside output state");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && $past(r_state) == S_WALK)
        |-> r_rd_ptr == $past(r_rd_ptr) + AW'(1))
        else $error("walk pointer skipped");

endmodule

`default_nettype wire
